// ===== src/bee_pkg.sv =====
// ----------------------------------------------------------------------------
// bee_pkg
// Shared request codes, sequencer states and the result word layout for the
// boundary edge extractor.
// ----------------------------------------------------------------------------
package bee_pkg;

  // Request codes carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_FETCH = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_SCAN,
    ST_REPLY
  } state_t;

  // Width of one vertex index on the ports.
  localparam int unsigned VERT_W = 16;

  // Number of edges formed from one triangle, less one.
  localparam logic [1:0] LAST_EDGE = 2'd2;

  // Use counts kept in the table.
  localparam logic [1:0] USES_ONE = 2'd1;
  localparam logic [1:0] USES_MAX = 2'd2;

  // One result word.
  typedef struct packed {
    logic [VERT_W-1:0] edge_low;
    logic [VERT_W-1:0] edge_high;
    logic              edge_valid;
    logic              fetch_done;
    logic              status;
  } result_t;

endpackage

// ===== src/bee_table.sv =====
// ----------------------------------------------------------------------------
// bee_table
// Edge table memory: one entry holds an edge key and its use count. One
// write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bee_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 34,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bee_ctrl.sv =====
// ----------------------------------------------------------------------------
// bee_ctrl
// Request sequencer: walks the edge table one entry a cycle to look up or
// insert triangle edges, or to find the next boundary edge, and builds the
// result word.
// ----------------------------------------------------------------------------
module bee_ctrl
  import bee_pkg::*;
#(
  parameter int unsigned EDGE_CAPACITY = 256,
  parameter int unsigned INDEX_BITS    = 16,
  parameter int unsigned KEY_W         = 2 * INDEX_BITS,
  parameter int unsigned ADDR_W        = $clog2(EDGE_CAPACITY),
  parameter int unsigned FILL_W        = $clog2(EDGE_CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  // Request side
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [1:0]          req_code,
  input  logic [VERT_W-1:0]   vert_a,
  input  logic [VERT_W-1:0]   vert_b,
  input  logic [VERT_W-1:0]   vert_c,
  // Result side
  output logic                res_valid,
  input  logic                res_take,
  output result_t             res,
  // Table port
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output logic [KEY_W+1:0]    wr_data,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  input  logic [KEY_W+1:0]    rd_data
);

  state_t state, state_next;

  logic [INDEX_BITS-1:0] v0, v1, v2;
  logic                  req_add;
  logic [1:0]            edge_sel;
  logic [KEY_W-1:0]      cur_key;
  logic [FILL_W-1:0]     fill_level;
  logic [FILL_W-1:0]     rd_idx;
  logic [ADDR_W-1:0]     cmp_idx;
  logic                  rd_pend;
  logic                  dropped;
  logic [KEY_W-1:0]      best;
  logic                  found;
  logic [KEY_W-1:0]      fetch_cursor;
  logic                  cursor_started;

  logic                  accept;
  logic                  more;
  logic                  scan_end;
  logic                  hit;
  logic                  table_full;
  logic                  edge_finish;
  logic                  cand;
  logic [KEY_W-1:0]      rd_key;
  logic [1:0]            rd_uses;
  logic [1:0]            uses_sat;
  logic [INDEX_BITS-1:0] ea, eb, e_lo, e_hi;
  logic [INDEX_BITS-1:0] in_a, in_b, in_c;
  logic [INDEX_BITS+VERT_W-1:0] lo_ext, hi_ext;

  // Vertex indices are taken in their low INDEX_BITS bits.
  assign in_a = INDEX_BITS'(vert_a);
  assign in_b = INDEX_BITS'(vert_b);
  assign in_c = INDEX_BITS'(vert_c);

  // Ends of the current edge and its ordered key.
  always_comb begin
    case (edge_sel)
      2'd0: begin
        ea = v0;
        eb = v1;
      end
      2'd1: begin
        ea = v1;
        eb = v2;
      end
      default: begin
        ea = v2;
        eb = v0;
      end
    endcase
    e_lo = (ea < eb) ? ea : eb;
    e_hi = (ea < eb) ? eb : ea;
  end

  // Table read data and scan conditions.
  assign rd_key      = rd_data[KEY_W+1:2];
  assign rd_uses     = rd_data[1:0];
  assign uses_sat    = (rd_uses == USES_MAX) ? USES_MAX : rd_uses + 2'd1;
  assign accept      = (state == ST_IDLE) && req_valid;
  assign more        = rd_idx < fill_level;
  assign scan_end    = (state == ST_SCAN) && !rd_pend && !more;
  assign hit         = (state == ST_SCAN) && req_add && rd_pend && (rd_key == cur_key);
  assign table_full  = fill_level == FILL_W'(EDGE_CAPACITY);
  assign edge_finish = req_add && (hit || scan_end);
  assign cand        = (state == ST_SCAN) && !req_add && rd_pend &&
                       (rd_uses == USES_ONE) &&
                       (!cursor_started || (rd_key > fetch_cursor)) &&
                       (!found || (rd_key < best));

  // Ends of the best key, widened to the port width.
  assign lo_ext = {{VERT_W{1'b0}}, best[KEY_W-1:INDEX_BITS]};
  assign hi_ext = {{VERT_W{1'b0}}, best[INDEX_BITS-1:0]};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_code)
            REQ_ADD:   state_next = ST_KEY;
            REQ_FETCH: state_next = ST_SCAN;
            default:   state_next = ST_REPLY;
          endcase
        end
      end
      ST_KEY: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (edge_finish) begin
          state_next = (edge_sel == LAST_EDGE) ? ST_REPLY : ST_KEY;
        end else if (!req_add && scan_end) begin
          state_next = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Handshake and table port controls.
  always_comb begin
    req_ready = (state == ST_IDLE);
    res_valid = (state == ST_REPLY);
    rd_en     = (state == ST_SCAN) && more;
    rd_addr   = rd_idx[ADDR_W-1:0];
    wr_en     = hit || (req_add && scan_end && !table_full);
    wr_addr   = hit ? cmp_idx : fill_level[ADDR_W-1:0];
    wr_data   = hit ? {cur_key, uses_sat} : {cur_key, USES_ONE};
  end

  // Sequencer and table bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      fill_level     <= '0;
      rd_pend        <= 1'b0;
      cursor_started <= 1'b0;
      fetch_cursor   <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (accept && (req_code == REQ_CLEAR)) begin
        fill_level     <= '0;
        cursor_started <= 1'b0;
        fetch_cursor   <= '0;
      end
      if (req_add && scan_end && !table_full) begin
        fill_level <= fill_level + FILL_W'(1);
      end
      if (!req_add && scan_end) begin
        cursor_started <= found;
        fetch_cursor   <= found ? best : '0;
      end
    end
  end

  // Payload registers of the running request.
  always_ff @(posedge clk) begin
    if (accept) begin
      v0       <= in_a;
      v1       <= in_b;
      v2       <= in_c;
      req_add  <= (req_code == REQ_ADD);
      edge_sel <= 2'd0;
      dropped  <= 1'b0;
      found    <= 1'b0;
      rd_idx   <= '0;
      res      <= '0;
    end
    if (state == ST_KEY) begin
      cur_key <= {e_lo, e_hi};
      rd_idx  <= '0;
    end
    if (rd_en) begin
      rd_idx  <= rd_idx + FILL_W'(1);
      cmp_idx <= rd_idx[ADDR_W-1:0];
    end
    if (cand) begin
      best  <= rd_key;
      found <= 1'b1;
    end
    if (req_add && scan_end && table_full) begin
      dropped <= 1'b1;
    end
    if (edge_finish) begin
      edge_sel   <= edge_sel + 2'd1;
      res.status <= dropped || (scan_end && table_full);
    end
    if (!req_add && scan_end) begin
      res.edge_low   <= found ? lo_ext[VERT_W-1:0] : '0;
      res.edge_high  <= found ? hi_ext[VERT_W-1:0] : '0;
      res.edge_valid <= found;
      res.fetch_done <= !found;
    end
  end

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(EDGE_CAPACITY))
    else $error("fill level beyond table capacity");

  // Only entries below the fill level are ever compared.
  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (FILL_W'(cmp_idx) < fill_level))
    else $error("compare of an unfilled table entry");

  // The table is written only while scanning for an add.
  a_write_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((state == ST_SCAN) && req_add))
    else $error("table write outside an add scan");

  // A fetch result is either an edge or done, never both.
  a_fetch_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.edge_valid && res.fetch_done))
    else $error("fetch result both valid and done");

  // A new table entry raises the fill count by exactly one.
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !hit) |=> (fill_level == $past(fill_level) + FILL_W'(1)))
    else $error("fill level not advanced on insert");

endmodule

// ===== src/boundary_edge_extractor.sv =====
// ----------------------------------------------------------------------------
// boundary_edge_extractor
// Collects the distinct edges of a triangle stream and returns the boundary
// edges (used exactly once) in ascending order on request.
//
// Usage:
//   Requests arrive on the s_ channel: s_tuser holds the request code (add
//   triangle, fetch next boundary edge, clear table) and s_tdata the three
//   vertex indices of a triangle. Every request gives exactly one word on
//   the m_ channel: the fetched edge in m_tdata and the edge valid, fetch
//   done and overflow flags in m_tuser.
//   The table is walked one entry a cycle through a single read port, so an
//   add walks the stored edges once per edge of its triangle, a fetch walks
//   them once and a clear needs no walk. One request is in work at a time.
//   The result sits in an output register, so the next request is taken
//   while an earlier word still waits for m_tready; a stalled receiver only
//   holds back the request after that one.
//   Reset leaves the table empty and the fetch cursor at its start; no
//   clearing pass is needed. A fetch that finds no further boundary edge
//   reports done and restarts the cursor.
// ----------------------------------------------------------------------------
module boundary_edge_extractor
  import bee_pkg::*;
#(
  parameter int unsigned EDGE_CAPACITY = 256,
  parameter int unsigned INDEX_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Request words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // vert_first, vert_second, vert_third
  input  logic [1:0]  s_tuser,   // req_type
  // Result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // edge_low, edge_high
  output logic [2:0]  m_tuser    // edge_valid, fetch_done, status
);

  localparam int unsigned KEY_W  = 2 * INDEX_BITS;
  localparam int unsigned ADDR_W = $clog2(EDGE_CAPACITY);
  localparam int unsigned FILL_W = $clog2(EDGE_CAPACITY + 1);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [KEY_W+1:0]  wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W+1:0]  rd_data;
  logic              res_valid;
  logic              res_take;
  result_t           res;
  logic              out_full;
  result_t           out_res;

  bee_ctrl #(
    .EDGE_CAPACITY (EDGE_CAPACITY),
    .INDEX_BITS    (INDEX_BITS),
    .KEY_W         (KEY_W),
    .ADDR_W        (ADDR_W),
    .FILL_W        (FILL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_code  (s_tuser),
    .vert_a    (s_tdata[15:0]),
    .vert_b    (s_tdata[31:16]),
    .vert_c    (s_tdata[47:32]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  bee_table #(
    .DEPTH  (EDGE_CAPACITY),
    .DATA_W (KEY_W + 2),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: takes a finished result when empty or being drained.
  assign res_take = !out_full || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid && res_take) begin
      out_full <= 1'b1;
    end else if (m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {out_res.edge_high, out_res.edge_low};
  assign m_tuser  = {out_res.status, out_res.fetch_done, out_res.edge_valid};

endmodule

// ===== test/boundary_edge_extractor_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_edge_extractor_checker
// Watches the request and result channels of the boundary edge extractor.
// It keeps its own copy of the edge table and fetch cursor, works out the
// result word of every accepted request, and compares each result word
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module boundary_edge_extractor_checker
  import bee_pkg::*;
#(
  parameter int unsigned EDGE_CAPACITY = 256,
  parameter int unsigned INDEX_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // vert_first, vert_second, vert_third
  input  logic [1:0]  s_tuser,   // req_type
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // edge_low, edge_high
  input  logic [2:0]  m_tuser,   // edge_valid, fetch_done, status
  output int          fail_count,
  output int          pending
);

  // Shadow edge table; keys are (low << INDEX_BITS) | high.
  longint unsigned tab_key   [EDGE_CAPACITY];
  logic [1:0]      tab_uses  [EDGE_CAPACITY];
  bit              tab_valid [EDGE_CAPACITY];
  int unsigned     tab_fill;

  // Fetch cursor: key of the last edge handed out.
  longint unsigned walk_key;
  bit              walk_started;

  // Predicted result words, oldest first.
  result_t reply_q[$];

  // Empties the table and restarts the fetch cursor. Keys stay as they are,
  // since they are only looked at behind a valid bit.
  task automatic clear_table();
    for (int i = 0; i < EDGE_CAPACITY; i++) begin
      tab_valid[i] = 1'b0;
      tab_uses[i]  = '0;
    end
    tab_fill     = 0;
    walk_key     = 0;
    walk_started = 1'b0;
  endtask

  // Enters one edge, raising its use count; lost is set when a new edge
  // finds the table full.
  task automatic enter_pair(input longint unsigned a, input longint unsigned b,
                            output bit lost);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned key;
    bit              hit;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    key  = (lo << INDEX_BITS) | hi;
    lost = 1'b0;
    hit  = 1'b0;
    for (int i = 0; i < EDGE_CAPACITY && !hit; i++) begin
      if (tab_valid[i] && tab_key[i] == key) begin
        hit = 1'b1;
        if (tab_uses[i] < USES_MAX) tab_uses[i] = tab_uses[i] + 1'b1;
      end
    end
    if (!hit) begin
      if (tab_fill >= EDGE_CAPACITY) begin
        lost = 1'b1;
      end else begin
        tab_key[tab_fill]   = key;
        tab_uses[tab_fill]  = USES_ONE;
        tab_valid[tab_fill] = 1'b1;
        tab_fill++;
      end
    end
  endtask

  // Applies one request to the shadow state and returns its result word.
  task automatic predict_reply(input logic [1:0] code, input logic [47:0] verts,
                               output result_t r);
    longint unsigned mask;
    longint unsigned v0;
    longint unsigned v1;
    longint unsigned v2;
    longint unsigned best;
    bit              lost0;
    bit              lost1;
    bit              lost2;
    bit              found;
    r    = '0;
    mask = (64'd1 << INDEX_BITS) - 1;
    case (code)
      REQ_ADD: begin
        v0 = verts[15:0] & mask;
        v1 = verts[31:16] & mask;
        v2 = verts[47:32] & mask;
        // Edges go in one after another, so a repeated edge counts twice.
        enter_pair(v0, v1, lost0);
        enter_pair(v1, v2, lost1);
        enter_pair(v2, v0, lost2);
        r.status = lost0 | lost1 | lost2;
      end
      REQ_FETCH: begin
        found = 1'b0;
        best  = 0;
        for (int i = 0; i < EDGE_CAPACITY; i++) begin
          if (!tab_valid[i] || tab_uses[i] != USES_ONE) continue;
          if (walk_started && tab_key[i] <= walk_key) continue;
          if (!found || tab_key[i] < best) begin
            best  = tab_key[i];
            found = 1'b1;
          end
        end
        if (found) begin
          walk_key     = best;
          walk_started = 1'b1;
          r.edge_low   = VERT_W'((best >> INDEX_BITS) & mask);
          r.edge_high  = VERT_W'(best & mask);
          r.edge_valid = 1'b1;
        end else begin
          // Nothing left: report done and start over next time.
          walk_key     = 0;
          walk_started = 1'b0;
          r.fetch_done = 1'b1;
        end
      end
      REQ_CLEAR: clear_table();
      default: ;  // The unused code leaves the state alone.
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Retire result words first, then predict the request taken on the same
  // edge, so a word with nothing outstanding is never matched by mistake.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_table();
      reply_q.delete();
      fail_count = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          $error("Result word 0x%0h/0x%0h arrived with no request outstanding",
                 m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("edge_low",   want.edge_low,   m_tdata[15:0]);
          check_field("edge_high",  want.edge_high,  m_tdata[31:16]);
          check_field("edge_valid", want.edge_valid, m_tuser[0]);
          check_field("fetch_done", want.fetch_done, m_tuser[1]);
          check_field("status",     want.status,     m_tuser[2]);
        end
      end
      if (s_tvalid && s_tready) begin
        predict_reply(s_tuser, s_tdata, want);
        reply_q.push_back(want);
      end
    end
    pending = reply_q.size();
  end

endmodule

// ===== test/boundary_edge_extractor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_edge_extractor_tb
// Drives add, fetch and clear requests into the boundary edge extractor:
// a short directed sequence, then triangle strips with shared edges, table
// overflow runs and random noise. Requests come in bursts with random gaps
// and the result side stalls on its own pattern; the checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module boundary_edge_extractor_tb;
  import bee_pkg::*;

  localparam int unsigned EDGE_CAPACITY = 256;
  localparam int unsigned INDEX_BITS    = 16;

  // Request code the block does not use; it must be ignored.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Stimulus stops once this many meaningful requests have gone in.
  localparam int unsigned TARGET_REQS = 700;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // vert_first, vert_second, vert_third
  logic [1:0]  s_tuser  = '0;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // edge_low, edge_high
  logic [2:0]  m_tuser;         // edge_valid, fetch_done, status

  int fail_count;
  int pending;

  int burst_left = 0;
  int sent_count = 0;
  int ready_run  = 0;
  int fill_runs  = 0;

  boundary_edge_extractor #(
    .EDGE_CAPACITY(EDGE_CAPACITY),
    .INDEX_BITS   (INDEX_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  boundary_edge_extractor_checker #(
    .EDGE_CAPACITY(EDGE_CAPACITY),
    .INDEX_BITS   (INDEX_BITS)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: long fully ready stretches mixed with short random stalls.
  always @(posedge clk) begin
    if (ready_run == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b1;
        ready_run = $urandom_range(40, 200);
      end else begin
        m_tready <= 1'($urandom_range(0, 1));
        ready_run = $urandom_range(1, 8);
      end
    end else begin
      ready_run--;
    end
  end

  // Sends one request word. A new burst may start after an idle gap; the
  // valid is only lowered when a gap really follows.
  task automatic send_req(input logic [1:0] code, input logic [15:0] va,
                          input logic [15:0] vb, input logic [15:0] vc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {vc, vb, va};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (code != REQ_SPARE) sent_count++;
  endtask

  // Adds a triangle in a random rotation and winding; the edges stay the same.
  task automatic add_tri(input logic [15:0] a, input logic [15:0] b,
                         input logic [15:0] c);
    logic [15:0] t;
    if ($urandom_range(0, 1) == 1) begin
      t = b;
      b = c;
      c = t;
    end
    case ($urandom_range(0, 2))
      0:       send_req(REQ_ADD, a, b, c);
      1:       send_req(REQ_ADD, b, c, a);
      default: send_req(REQ_ADD, c, a, b);
    endcase
  endtask

  task automatic fetch_next();
    send_req(REQ_FETCH, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // A grid strip of triangles: inner edges are shared, the rim is boundary.
  // Fetches are mixed in so that adds also land between fetches.
  task automatic run_mesh_phase();
    int          cols;
    int          rows;
    int          fetches;
    logic [15:0] base;
    logic [15:0] v;
    logic [15:0] qa[$];
    logic [15:0] qb[$];
    logic [15:0] qc[$];
    if ($urandom_range(0, 4) != 0) send_req(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
    cols = $urandom_range(2, 6);
    rows = $urandom_range(1, 4);
    base = 16'($urandom);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols - 1; c++) begin
        v = base + 16'(r * cols + c);
        qa.push_back(v);
        qb.push_back(v + 16'd1);
        qc.push_back(v + 16'(cols));
        qa.push_back(v + 16'd1);
        qb.push_back(v + 16'(cols + 1));
        qc.push_back(v + 16'(cols));
        // Now and then a repeated or a degenerate triangle.
        if ($urandom_range(0, 9) == 0) begin
          qa.push_back(v);
          qb.push_back(v + 16'd1);
          qc.push_back(v + 16'(cols));
        end
        if ($urandom_range(0, 14) == 0) begin
          qa.push_back(v);
          qb.push_back(v);
          qc.push_back(v + 16'd1);
        end
      end
    end
    fetches = 2 * (cols - 1) + 2 * rows + $urandom_range(0, 3);
    while (qa.size() != 0 || fetches > 0) begin
      if (qa.size() != 0 && (fetches == 0 || $urandom_range(0, 4) != 0)) begin
        add_tri(qa.pop_front(), qb.pop_front(), qc.pop_front());
      end else begin
        fetch_next();
        fetches--;
      end
    end
  endtask

  // Fills the table with disjoint triangles until it overflows, then mixes
  // adds of known edges with adds that still bring new ones.
  task automatic run_fill_phase();
    logic [15:0] base;
    logic [15:0] v;
    send_req(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
    base = 16'($urandom);
    v    = base;
    for (int t = 0; t < 90; t++) begin
      add_tri(v, v + 16'd1, v + 16'd2);
      v = v + 16'd3;
    end
    add_tri(base, base + 16'd1, base + 16'd2);
    add_tri(base + 16'd3, base + 16'd4, v + 16'd7);
    repeat ($urandom_range(3, 10)) fetch_next();
    fill_runs++;
  endtask

  // Random requests over the whole field ranges, small vertex sets now and
  // then so that edges collide.
  task automatic run_noise_phase();
    int          pick;
    bit          narrow;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    repeat ($urandom_range(5, 20)) begin
      pick   = $urandom_range(0, 9);
      narrow = ($urandom_range(0, 1) == 1);
      a = narrow ? 16'($urandom_range(0, 7)) : 16'($urandom);
      b = narrow ? 16'($urandom_range(0, 7)) : 16'($urandom);
      c = narrow ? 16'($urandom_range(0, 7)) : 16'($urandom);
      if (pick < 5)       send_req(REQ_ADD, a, b, c);
      else if (pick < 8)  send_req(REQ_FETCH, a, b, c);
      else if (pick == 8) send_req(REQ_CLEAR, a, b, c);
      else                send_req(REQ_SPARE, a, b, c);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty fetch, extreme and degenerate edges, fetch order and
    // restart, adds between fetches, the unused code and clear.
    fetch_next();
    send_req(REQ_ADD, 16'h0000, 16'hFFFF, 16'h0000);
    send_req(REQ_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(REQ_ADD, 16'd1, 16'd2, 16'd3);
    repeat (6) fetch_next();
    send_req(REQ_ADD, 16'd0, 16'd1, 16'd4);
    fetch_next();
    send_req(REQ_SPARE, 16'hA5A5, 16'h5A5A, 16'hFFFF);
    fetch_next();
    fetch_next();
    send_req(REQ_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    fetch_next();
    send_req(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000);

    // Random part: mostly triangle strips, two overflow runs, some noise.
    while (sent_count < TARGET_REQS) begin
      if (fill_runs == 0 || (fill_runs == 1 && sent_count >= 400)) begin
        run_fill_phase();
      end else if ($urandom_range(0, 4) == 0) begin
        run_noise_phase();
      end else begin
        run_mesh_phase();
      end
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every predicted word, then let the clock run on before finishing.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #25_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bee_pkg.sv
src/bee_table.sv
src/bee_ctrl.sv
src/boundary_edge_extractor.sv
test/boundary_edge_extractor_checker.sv
test/boundary_edge_extractor_tb.sv
